// ===== rtl/kpudc_pkg.sv =====
// Shared types, constants and helper functions for the keypad up/down counter.
// Holds the BCD step functions and the seven-segment decode; no dependencies.
package kpudc_pkg;

  localparam int unsigned COUNT_W    = 14;
  localparam int unsigned DEBOUNCE_W = 16;
  localparam int unsigned REPEAT_W   = 8;
  localparam int unsigned KEYS_W     = 16;
  localparam int unsigned SEG_W      = 7;
  localparam int unsigned SEL_W      = 2;
  localparam int unsigned DIGITS     = 4;
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [COUNT_W-1:0]    DECIMAL_MAX        = 14'd9999;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET     = 16'd50;
  localparam logic [REPEAT_W-1:0]   REPEAT_RESET       = 8'd250;
  localparam logic [COUNT_W-1:0]    MAX_COUNT_RESET    = 14'd9999;

  // Register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_DEBOUNCE_LIMIT = 2'd0;
  localparam logic [1:0] REG_REPEAT_LIMIT   = 2'd1;
  localparam logic [1:0] REG_MAX_COUNT      = 2'd2;

  typedef logic [DIGITS-1:0][3:0] bcd_t;

  typedef struct packed {
    logic up;
    logic down;
  } step_t;

  function automatic bcd_t bcd_inc(bcd_t v);
    bcd_t r;
    logic c;
    r = v;
    c = 1'b1;
    for (int i = 0; i < DIGITS; i++) begin
      if (c) begin
        if (v[i] == 4'd9) begin
          r[i] = 4'd0;
        end else begin
          r[i] = v[i] + 4'd1;
          c    = 1'b0;
        end
      end
    end
    return r;
  endfunction

  function automatic bcd_t bcd_dec(bcd_t v);
    bcd_t r;
    logic b;
    r = v;
    b = 1'b1;
    for (int i = 0; i < DIGITS; i++) begin
      if (b) begin
        if (v[i] == 4'd0) begin
          r[i] = 4'd9;
        end else begin
          r[i] = v[i] - 4'd1;
          b    = 1'b0;
        end
      end
    end
    return r;
  endfunction

  // Bit 0 is segment a, bit 6 segment g; codes above nine show as nine
  function automatic logic [SEG_W-1:0] seg7(logic [3:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      default: s = 7'h6F;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/kpudc_counter.sv =====
// Saturating up/down counter kept both in binary and as four BCD digits.
// Depends on kpudc_pkg for the step struct and the BCD step functions.
module kpudc_counter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  kpudc_pkg::step_t                step_i,
  input  logic [kpudc_pkg::COUNT_W-1:0]   max_count_i,
  output logic [kpudc_pkg::COUNT_W-1:0]   count_d_o,
  output kpudc_pkg::bcd_t                 bcd_d_o
);
  import kpudc_pkg::*;

  logic [COUNT_W-1:0] count_q, count_d, bound;
  bcd_t               bcd_q, bcd_d;

  assign bound = (max_count_i < DECIMAL_MAX) ? max_count_i : DECIMAL_MAX;

  always_comb begin
    count_d = count_q;
    bcd_d   = bcd_q;
    if (step_i.up && (count_q < bound)) begin
      count_d = count_q + 14'd1;
      bcd_d   = bcd_inc(bcd_q);
    end else if (step_i.down && (count_q != '0)) begin
      count_d = count_q - 14'd1;
      bcd_d   = bcd_dec(bcd_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      bcd_q   <= '0;
    end else begin
      count_q <= count_d;
      bcd_q   <= bcd_d;
    end
  end

  assign count_d_o = count_d;
  assign bcd_d_o   = bcd_d;

endmodule

// ===== rtl/keypad_up_down_counter_display_top.sv =====
// Top level of the keypad up/down counter with multiplexed seven-segment display.
// Depends on kpudc_pkg and kpudc_counter.
//
//  Channel  Direction  Handshake                Payload
//  input    in         in_valid_i / in_stall_o  key_matrix_i
//  output   out        out_valid_o / out_stall_i  digit_select_o, segments_o, count_value_o
//  config   in         APB psel/penable/pwrite  paddr (4 bit), pwdata/prdata (32 bit)
//
// One transaction per cycle sustained while the output does not stall. A key
// transaction is held in the input register, then the key decode, debounce/repeat
// update and counter step run in one pass and land in the result register.
// Reset clears the counter, the debounce/repeat state, the scan index and both
// valid flags; the registers return to 50, 250 and 9999.
// A stall on the output holds the result register and backs up into the input
// register; in_stall_o rises only when both are full.
module keypad_up_down_counter_display_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // key transactions
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [kpudc_pkg::KEYS_W-1:0]         key_matrix_i,
  // display transactions
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [kpudc_pkg::SEL_W-1:0]          digit_select_o,
  output logic [kpudc_pkg::SEG_W-1:0]          segments_o,
  output logic [kpudc_pkg::COUNT_W-1:0]        count_value_o,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [kpudc_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [kpudc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [kpudc_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                 pready
);
  import kpudc_pkg::*;

  // Configuration registers
  logic [DEBOUNCE_W-1:0] debounce_limit_q;
  logic [REPEAT_W-1:0]   repeat_limit_q;
  logic [COUNT_W-1:0]    max_count_q;
  logic                  cfg_wr;
  logic [1:0]            cfg_idx;

  // Pipeline
  logic                  in_valid_q;
  logic [KEYS_W-1:0]     key_q;
  logic                  out_valid_q;
  logic [SEL_W-1:0]      digit_select_q;
  logic [SEG_W-1:0]      segments_q;
  logic [COUNT_W-1:0]    count_value_q;
  logic                  out_advance, fire;

  // Key state
  logic                  armed_q, armed_d;
  logic [DEBOUNCE_W-1:0] release_q, release_d, release_inc;
  logic [REPEAT_W-1:0]   hold_q, hold_d, hold_inc;
  logic [SEL_W-1:0]      digit_idx_q, digit_idx_d, digit_sel;
  logic                  no_key, key_up, key_down, key_rpt_up, key_rpt_down;
  step_t                 step;
  logic [COUNT_W-1:0]    count_next;
  bcd_t                  bcd_next;

  // ---------------------------------------------------------------------------
  // APB register file; pready always high, decode on paddr[3:2]
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_limit_q <= DEBOUNCE_RESET;
      repeat_limit_q   <= REPEAT_RESET;
      max_count_q      <= MAX_COUNT_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DEBOUNCE_LIMIT: debounce_limit_q <= pwdata[DEBOUNCE_W-1:0];
        REG_REPEAT_LIMIT:   repeat_limit_q   <= pwdata[REPEAT_W-1:0];
        REG_MAX_COUNT:      max_count_q      <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DEBOUNCE_LIMIT: prdata = {{(APB_DATA_W-DEBOUNCE_W){1'b0}}, debounce_limit_q};
      REG_REPEAT_LIMIT:   prdata = {{(APB_DATA_W-REPEAT_W){1'b0}}, repeat_limit_q};
      REG_MAX_COUNT:      prdata = {{(APB_DATA_W-COUNT_W){1'b0}}, max_count_q};
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake: the result register drains first, the input register follows
  // ---------------------------------------------------------------------------
  assign out_advance = !out_valid_q || !out_stall_i;
  assign fire        = in_valid_q && out_advance;
  assign in_stall_o  = in_valid_q && !out_advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      key_q <= key_matrix_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Key decode: lowest pressed key wins, only keys 1, 2, 5 and 6 do anything
  // ---------------------------------------------------------------------------
  assign no_key       = (key_q == '0);
  assign key_up       = key_q[0];
  assign key_down     = (key_q[1:0] == 2'b10);
  assign key_rpt_up   = (key_q[3:0] == 4'b0000) && key_q[4];
  assign key_rpt_down = (key_q[4:0] == 5'b00000) && key_q[5];

  assign release_inc = release_q + 16'd1;
  assign hold_inc    = hold_q + 8'd1;

  always_comb begin
    armed_d   = armed_q;
    release_d = release_q;
    hold_d    = hold_q;
    step      = '0;
    if (no_key) begin
      // Count release ticks until the debounce limit is passed, then re-arm
      hold_d = '0;
      if (!armed_q) begin
        if (release_inc > debounce_limit_q) begin
          release_d = '0;
          armed_d   = 1'b1;
        end else begin
          release_d = release_inc;
        end
      end else begin
        release_d = '0;
      end
    end else if (key_up || key_down) begin
      // Single step, then drop armed until the keypad has been released
      if (armed_q) begin
        armed_d   = 1'b0;
        step.up   = key_up;
        step.down = key_down;
      end
    end else if (key_rpt_up || key_rpt_down) begin
      // Auto-repeat: step each time the held count passes the limit
      if (armed_q) begin
        if (hold_inc > repeat_limit_q) begin
          hold_d    = '0;
          step.up   = key_rpt_up;
          step.down = key_rpt_down;
        end else begin
          hold_d = hold_inc;
        end
      end
    end
    if (!fire) begin
      step = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b0;
      release_q   <= '0;
      hold_q      <= '0;
      digit_idx_q <= '0;
    end else if (fire) begin
      armed_q     <= armed_d;
      release_q   <= release_d;
      hold_q      <= hold_d;
      digit_idx_q <= digit_idx_d;
    end
  end

  kpudc_counter u_counter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .max_count_i (max_count_q),
    .count_d_o   (count_next),
    .bcd_d_o     (bcd_next)
  );

  // ---------------------------------------------------------------------------
  // Display scan: index 0 shows thousands, so the select is its complement,
  // and the select is also the BCD digit position
  // ---------------------------------------------------------------------------
  assign digit_idx_d = digit_idx_q + 2'd1;
  assign digit_sel   = ~digit_idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_advance) begin
      out_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      digit_select_q <= digit_sel;
      segments_q     <= seg7(bcd_next[digit_sel]);
      count_value_q  <= count_next;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign digit_select_o = digit_select_q;
  assign segments_o     = segments_q;
  assign count_value_o  = count_value_q;

endmodule

// ===== rtl/kpudc_checker.sv =====
// Port-level checks for the keypad up/down counter top level, bound in below.
// Depends on kpudc_pkg and keypad_up_down_counter_display_top.
module kpudc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [kpudc_pkg::SEL_W-1:0]       digit_select_o,
  input logic [kpudc_pkg::SEG_W-1:0]       segments_o,
  input logic [kpudc_pkg::COUNT_W-1:0]     count_value_o
);
  import kpudc_pkg::*;

  logic               seen_q;
  logic [SEL_W-1:0]   last_sel_q;
  logic [COUNT_W-1:0] last_count_q;
  logic               out_acc;

  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q       <= 1'b0;
      last_sel_q   <= '0;
      last_count_q <= '0;
    end else if (out_acc) begin
      seen_q       <= 1'b1;
      last_sel_q   <= digit_select_o;
      last_count_q <= count_value_o;
    end
  end

  // A stalled result holds its whole payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(segments_o)
      && $stable(count_value_o) && $stable(digit_select_o))
    else $error("stalled result changed");

  // The scan moves down one digit per delivered result
  a_scan_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_q |-> digit_select_o == SEL_W'(last_sel_q - 2'd1))
    else $error("digit scan out of order");

  // The counter moves by at most one between delivered results
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_q |-> (count_value_o == last_count_q)
      || (count_value_o == last_count_q + 14'd1)
      || (last_count_q == count_value_o + 14'd1))
    else $error("counter jumped");

  // The count never leaves the decimal range
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> count_value_o <= DECIMAL_MAX)
    else $error("count above decimal range");

  // No stall on the input while the pipeline is empty of waiting results
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

endmodule

bind keypad_up_down_counter_display_top kpudc_checker u_kpudc_checker (.*);

// ===== dv/testbench.sv =====
// Self-checking testbench for keypad_up_down_counter_display_top.
// Holds its own tick-by-tick model of the keypad counter and display scan.
// Depends on kpudc_pkg and the RTL top level only.
module testbench;
  import kpudc_pkg::*;

  // Key numbers as the block sees them: bit k-1 of the matrix is key k
  localparam int KEY_NONE        = 0;
  localparam int KEY_UP          = 1;
  localparam int KEY_DOWN        = 2;
  localparam int KEY_REPEAT_UP   = 5;
  localparam int KEY_REPEAT_DOWN = 6;

  typedef struct packed {
    logic [SEL_W-1:0]   sel;
    logic [SEG_W-1:0]   seg;
    logic [COUNT_W-1:0] count;
  } scan_result_t;

  // Receiver back-pressure patterns, each held for a random stretch of cycles
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_SCATTER,
    STALL_THIRD,
    STALL_BLOCK
  } stall_mode_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [KEYS_W-1:0]     key_matrix_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [SEL_W-1:0]      digit_select_o;
  logic [SEG_W-1:0]      segments_o;
  logic [COUNT_W-1:0]    count_value_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  keypad_up_down_counter_display_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .key_matrix_i   (key_matrix_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .digit_select_o (digit_select_o),
    .segments_o     (segments_o),
    .count_value_o  (count_value_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Our copy of the registers, kept in step with every write on the bus
  logic [DEBOUNCE_W-1:0] cfg_debounce = DEBOUNCE_RESET;
  logic [REPEAT_W-1:0]   cfg_repeat   = REPEAT_RESET;
  logic [COUNT_W-1:0]    cfg_max      = MAX_COUNT_RESET;

  // Our copy of the block state
  logic [COUNT_W-1:0]    tally       = '0;
  logic                  step_armed  = 1'b0;
  logic [DEBOUNCE_W-1:0] quiet_ticks = '0;
  logic [REPEAT_W-1:0]   held_ticks  = '0;
  logic [1:0]            scan_pos    = '0;

  logic [KEYS_W-1:0] key_scans [$];        // key transactions still to be sent
  scan_result_t      pending_display [$];  // display transactions still owed
  int                fault_count = 0;

  int          burst_left;
  int          gap_left;
  stall_mode_t stall_mode;
  int          mode_left;
  int          stall_tick;
  scan_result_t want;

  initial forever #6 clk_i = ~clk_i;

  // Hold reset at the start, then release it for good
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Give up well past the slowest legal run
  initial begin
    #3_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  task automatic flag_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("mismatch: %s", msg);
  endtask

  // Advance the model by one scan tick and return the display transaction it owes
  function automatic scan_result_t display_tick(input logic [KEYS_W-1:0] keys);
    int           key;
    int           bound;
    int           digit;
    scan_result_t r;
    key = KEY_NONE;
    for (int i = KEYS_W - 1; i >= 0; i--) if (keys[i]) key = i + 1;
    bound = (cfg_max < DECIMAL_MAX) ? int'(cfg_max) : int'(DECIMAL_MAX);
    case (key)
      KEY_NONE: begin
        held_ticks = '0;
        if (!step_armed) begin
          quiet_ticks = quiet_ticks + 1'b1;
          if (quiet_ticks > cfg_debounce) begin
            quiet_ticks = '0;
            step_armed  = 1'b1;
          end
        end else begin
          quiet_ticks = '0;
        end
      end
      KEY_UP, KEY_DOWN: begin
        if (step_armed) begin
          step_armed = 1'b0;
          if (key == KEY_UP) begin
            if (tally < bound) tally++;
          end else if (tally > 0) begin
            tally--;
          end
        end
      end
      KEY_REPEAT_UP, KEY_REPEAT_DOWN: begin
        if (step_armed) begin
          held_ticks = held_ticks + 1'b1;
          if (held_ticks > cfg_repeat) begin
            held_ticks = '0;
            if (key == KEY_REPEAT_UP) begin
              if (tally < bound) tally++;
            end else if (tally > 0) begin
              tally--;
            end
          end
        end
      end
      default: ;
    endcase
    // Scan order runs thousands, hundreds, tens, units
    scan_pos = scan_pos + 1'b1;
    case (scan_pos)
      2'd0:    digit = tally / 1000;
      2'd1:    digit = (tally % 1000) / 100;
      2'd2:    digit = (tally % 100) / 10;
      default: digit = tally % 10;
    endcase
    if (digit > 9) digit = 9;
    case (digit)
      0:       r.seg = 7'h3F;
      1:       r.seg = 7'h06;
      2:       r.seg = 7'h5B;
      3:       r.seg = 7'h4F;
      4:       r.seg = 7'h66;
      5:       r.seg = 7'h6D;
      6:       r.seg = 7'h7D;
      7:       r.seg = 7'h07;
      8:       r.seg = 7'h7F;
      default: r.seg = 7'h6F;
    endcase
    r.sel   = 2'd3 - scan_pos;
    r.count = tally;
    return r;
  endfunction

  // Matrix whose lowest pressed key is the one given; higher keys are random
  function automatic logic [KEYS_W-1:0] pressed(input int key);
    logic [KEYS_W-1:0] v;
    v = $urandom;
    v = v & (16'hFFFF << key);
    if ($urandom_range(0, 3) == 0) v = '0;
    v[key-1] = 1'b1;
    return v;
  endfunction

  function automatic void hold_key(input int key, input int ticks);
    for (int i = 0; i < ticks; i++)
      key_scans.push_back((key == KEY_NONE) ? '0 : pressed(key));
  endfunction

  // Queue one random stretch of key activity and return its length in ticks
  function automatic int queue_episode();
    int r;
    int len;
    int k;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      // release long enough to re-arm, now and then cut short
      if ($urandom_range(0, 4) == 0) len = $urandom_range(0, cfg_debounce);
      else len = cfg_debounce + 1 + $urandom_range(0, 2);
      hold_key(KEY_NONE, len);
    end else if (r < 60) begin
      len = $urandom_range(1, 4);
      hold_key($urandom_range(0, 1) ? KEY_UP : KEY_DOWN, len);
    end else if (r < 80) begin
      len = $urandom_range(1, 2 * (cfg_repeat + 1) + 1);
      hold_key($urandom_range(0, 1) ? KEY_REPEAT_UP : KEY_REPEAT_DOWN, len);
    end else if (r < 90) begin
      // keys with no function: 3, 4 and 7 to 16
      k = $urandom_range(3, 14);
      if (k >= KEY_REPEAT_UP) k += 2;
      len = $urandom_range(1, 3);
      hold_key(k, len);
    end else begin
      len = $urandom_range(1, 4);
      for (int i = 0; i < len; i++) key_scans.push_back(KEYS_W'($urandom));
    end
    return len;
  endfunction

  // Wait until every transaction is sent and answered, then let the pipe empty
  task automatic settle();
    while (key_scans.size() != 0 || in_valid_i || pending_display.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write one register, then read it back
  task automatic write_reg(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] mask;
    case (idx)
      REG_DEBOUNCE_LIMIT: begin
        mask         = 32'h0000_FFFF;
        cfg_debounce = value[DEBOUNCE_W-1:0];
      end
      REG_REPEAT_LIMIT: begin
        mask       = 32'h0000_00FF;
        cfg_repeat = value[REPEAT_W-1:0];
      end
      default: begin
        mask    = 32'h0000_3FFF;
        cfg_max = value[COUNT_W-1:0];
      end
    endcase
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if ((prdata & mask) !== (value & mask))
      flag_fault($sformatf("register %0d reads %0h, wrote %0h", idx, prdata, value));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(input int debounce, input int repeat_lim, input int max_val);
    settle();
    write_reg(REG_DEBOUNCE_LIMIT, debounce);
    write_reg(REG_REPEAT_LIMIT, repeat_lim);
    write_reg(REG_MAX_COUNT, max_val);
  endtask

  // Driver: send key transactions in bursts with random gaps, predict each on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      key_matrix_i <= '0;
      burst_left   = 0;
      gap_left     = 0;
    end else begin
      if (in_valid_i && !in_stall_o) pending_display.push_back(display_tick(key_matrix_i));
      // hold the payload while stalled; otherwise the slot is free after this edge
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (key_scans.size() != 0) begin
          key_matrix_i <= key_scans.pop_front();
          in_valid_i   <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each display transaction against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_mode  = STALL_NONE;
      mode_left   = 0;
      stall_tick  = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_display.size() == 0) begin
          flag_fault($sformatf("display transaction with none owed: sel %0d seg %02h count %0d",
                               digit_select_o, segments_o, count_value_o));
        end else begin
          want = pending_display.pop_front();
          if (digit_select_o !== want.sel || segments_o !== want.seg ||
              count_value_o !== want.count)
            flag_fault($sformatf("sel %0d (want %0d) seg %02h (want %02h) count %0d (want %0d)",
                                 digit_select_o, want.sel, segments_o, want.seg,
                                 count_value_o, want.count));
        end
      end
      // pick a fresh back-pressure pattern every so often
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(20, 200);
      end
      mode_left--;
      stall_tick++;
      case (stall_mode)
        STALL_NONE:    out_stall_i <= 1'b0;
        STALL_SCATTER: out_stall_i <= ($urandom_range(0, 2) == 0);
        STALL_THIRD:   out_stall_i <= (stall_tick % 3 == 0);
        default:       out_stall_i <= (stall_tick % 10 < 6);
      endcase
    end
  end

  // Stimulus: directed opening, short runs at the register extremes, then random phases
  initial begin
    int n;
    logic [KEYS_W-1:0] opening [$] = '{
      16'h0000, 16'h0000,            // arm after two quiet ticks
      16'h0001,                      // single step up, disarm
      16'hFFFF, 16'h0010,            // presses ignored while disarmed
      16'h0000, 16'h0000,            // re-arm
      16'h0010, 16'hFFF0,            // auto-repeat up steps on the second tick
      16'h0010, 16'h0010,            // auto-repeat held at the upper bound
      16'h0020, 16'h8020,            // auto-repeat down
      16'h0004, 16'h8000,            // keys with no function
      16'h0002,                      // single step down, still armed after repeat
      16'h0000, 16'h0000,
      16'hFFFE,                      // step down from zero, clamped
      16'h0008
    };
    @(posedge rst_ni);

    configure(1, 1, 2);
    foreach (opening[i]) key_scans.push_back(opening[i]);

    // count up a stretch with a maximum above the decimal range
    configure(0, 0, 16383);
    hold_key(KEY_NONE, 1);
    hold_key(KEY_REPEAT_UP, 60);

    // drop the maximum under the current count: up is held, down still moves
    configure(0, 0, 5);
    hold_key(KEY_REPEAT_UP, 4);
    hold_key(KEY_REPEAT_DOWN, 3);
    hold_key(KEY_UP, 1);

    // maximum of zero: count down to the floor and stay there
    configure(0, 0, 0);
    hold_key(KEY_NONE, 1);
    hold_key(KEY_REPEAT_DOWN, 70);
    hold_key(KEY_REPEAT_UP, 3);

    // largest repeat limit: the held count wraps and never steps
    configure(0, 255, 9999);
    hold_key(KEY_NONE, 1);
    hold_key(KEY_REPEAT_UP, 270);
    hold_key(KEY_REPEAT_DOWN, 10);
    hold_key(KEY_UP, 1);

    // large debounce limit: a short release leaves the block disarmed
    configure(65534, 3, 3);
    hold_key(KEY_UP, 1);
    hold_key(KEY_NONE, 40);
    hold_key(KEY_DOWN, 1);
    hold_key(KEY_UP, 1);

    // debounce limit at full scale: presses stay ignored
    configure(65535, 254, 9999);
    hold_key(KEY_UP, 1);
    hold_key(KEY_NONE, 40);
    hold_key(KEY_UP, 1);
    hold_key(KEY_REPEAT_UP, 3);

    for (int p = 0; p < 6; p++) begin
      if (p == 2) configure(DEBOUNCE_RESET, REPEAT_RESET, MAX_COUNT_RESET);
      else configure($urandom_range(0, 6), $urandom_range(0, 6),
                     $urandom_range(0, 1) ? $urandom_range(0, 25) : $urandom_range(0, 16383));
      n = 0;
      while (n < 170) n += queue_episode();
    end

    settle();
    if (fault_count == 0 && pending_display.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
